// ----- hw/rtl/iaif_pkg.sv -----
// Shared types and codes for the indexed array store.
`default_nettype none

package iaif_pkg;

   typedef enum logic [2:0] {
      OP_GET,
      OP_SET,
      OP_FIND,
      OP_APPEND,
      OP_INSERT,
      OP_FIRST,
      OP_LAST,
      OP_RESTART
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_RANGE,
      ST_FULL,
      ST_MISSING
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_FIND,
      S_SHIFT,
      S_CLEAR,
      S_DONE
   } state_type;

   // word select of the start_length register (paddr[2])
   localparam logic REG_START_LENGTH = 1'b0;

endpackage

`default_nettype wire

// ----- hw/rtl/indexed_array_insert_find.sv -----
// Top level: indexed array store with get, set, find, append, insert, get first, get last and restart.
`default_nettype none

// Array store of CAPACITY words with a length register, one request at a time,
// one response per request. All entries live in a single simple dual-port RAM
// (one read and one write per cycle, registered read). Set and append write in
// the decode state; get, get first and get last read there and take the data
// in the read state, unless out of range or empty. Find reads one entry per
// cycle and stops at the first match or at the length. Insert moves one entry
// per cycle (read below, write above, overlapped), then writes the new value at
// the index; a rejected insert moves nothing. Restart writes zero to entries
// 0 .. L-1, L being start_length saturated to CAPACITY, and then sets the
// length to L. The RAM is not cleared after reset: an entry at or above the
// length is always written before it is read, so the length itself stands in
// for a clearing pass. A new request is taken while the previous response
// still waits in the output register.
module indexed_array_insert_find
   import iaif_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [9:0]  req_index,
   input  wire logic [31:0] req_value,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_value,
   output logic [9:0]       rsp_found_index,
   output logic [1:0]       rsp_status,
   output logic [10:0]      rsp_length,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > 11) ? LW : 11;
   localparam int VW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   state_type             state_ff, state_in;
   logic [LW-1:0]         cnt_ff, cnt_in;
   logic [10:0]           start_ff, start_in;
   opcode_type            op_ff, op_in;
   logic [9:0]            pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [LW-1:0]         ptr_ff, ptr_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [AW-1:0]         chk_idx_ff, chk_idx_in;
   logic [31:0]           res_value_ff, res_value_in;
   logic [9:0]            res_index_ff, res_index_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [9:0]            rsp_index_ff, rsp_index_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [10:0]           rsp_length_ff, rsp_length_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   logic [CW-1:0] cnt_w, pos_w, ptr_w, start_w, newlen_w, cnt_m1_w, ptr_m1_w, idx_w;
   logic [VW-1:0] val_ext, rdata_w;
   logic          full, in_range, find_issue, find_hit, shift_issue, clear_issue;
   logic          rsp_free, req_fire;

   iaif_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign cnt_w    = CW'(cnt_ff);
   assign pos_w    = CW'(pos_ff);
   assign ptr_w    = CW'(ptr_ff);
   assign start_w  = CW'(start_ff);
   assign newlen_w = (start_w > CAP_W) ? CAP_W : start_w;
   assign cnt_m1_w = cnt_w - CW'(1);
   assign ptr_m1_w = ptr_w - CW'(1);
   assign idx_w    = CW'(chk_idx_ff);
   assign val_ext  = VW'(req_value);
   assign rdata_w  = VW'(mem_rdata);

   assign full        = (cnt_w >= CAP_W);
   assign in_range    = (pos_w < cnt_w);
   assign find_issue  = (ptr_w < cnt_w);
   assign find_hit    = chk_valid_ff && (mem_rdata == val_ff);
   assign shift_issue = (ptr_w > pos_w);
   assign clear_issue = (ptr_w < newlen_w);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // configuration port
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == REG_START_LENGTH) ? {21'd0, start_ff} : 32'd0;
   assign start_in = (psel && penable && pwrite && paddr[2] == REG_START_LENGTH)
                     ? pwdata[10:0] : start_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (op_ff)
               OP_GET:     state_in = in_range ? S_READ : S_DONE;
               OP_FIND:    state_in = S_FIND;
               OP_INSERT:  state_in = (!full && pos_w <= cnt_w) ? S_SHIFT : S_DONE;
               OP_FIRST,
               OP_LAST:    state_in = (cnt_w != '0) ? S_READ : S_DONE;
               OP_RESTART: state_in = S_CLEAR;
               default:    state_in = S_DONE;
            endcase
         end
         S_READ:  state_in = S_DONE;
         S_FIND: begin
            if (find_hit || !find_issue) state_in = S_DONE;
         end
         S_SHIFT: begin
            if (!shift_issue && !chk_valid_ff) state_in = S_DONE;
         end
         S_CLEAR: begin
            if (!clear_issue) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      res_value_in  = res_value_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in  = opcode_type'(req_opcode);
               pos_in = req_index;
               val_in = val_ext[DATA_WIDTH-1:0];
            end
         end
         S_DECODE: begin
            res_value_in  = '0;
            res_index_in  = '0;
            res_status_in = ST_OK;
            ptr_in        = '0;
            chk_valid_in  = 1'b0;
            case (op_ff)
               OP_GET: begin
                  if (in_range) begin
                     mem_re    = 1'b1;
                     mem_raddr = pos_w[AW-1:0];
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               OP_SET: begin
                  if (in_range) begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_w[AW-1:0];
                     mem_wdata = val_ff;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               OP_APPEND: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = cnt_w[AW-1:0];
                     mem_wdata = val_ff;
                     cnt_in    = cnt_ff + LW'(1);
                  end
               end
               OP_INSERT: begin
                  // full is checked before the index
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else if (pos_w > cnt_w) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     ptr_in = cnt_ff;
                  end
               end
               OP_FIRST: begin
                  if (cnt_w == '0) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                  end
               end
               OP_LAST: begin
                  if (cnt_w == '0) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = cnt_m1_w[AW-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            res_value_in = rdata_w[31:0];
         end
         S_FIND: begin
            // read entry ptr while comparing the one read last cycle
            if (find_issue) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_w[AW-1:0];
               ptr_in    = ptr_ff + LW'(1);
            end
            chk_valid_in = find_issue;
            chk_idx_in   = ptr_w[AW-1:0];
            if (find_hit) begin
               res_status_in = ST_OK;
               res_index_in  = idx_w[9:0];
            end else if (!find_issue) begin
               res_status_in = ST_MISSING;
            end
         end
         S_SHIFT: begin
            // ptr is the destination; read ptr-1 now, write it one slot up next cycle
            if (shift_issue) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_m1_w[AW-1:0];
               ptr_in    = ptr_m1_w[LW-1:0];
            end
            chk_valid_in = shift_issue;
            chk_idx_in   = ptr_w[AW-1:0];
            if (chk_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = chk_idx_ff;
               mem_wdata = mem_rdata;
            end else if (!shift_issue) begin
               mem_we    = 1'b1;
               mem_waddr = pos_w[AW-1:0];
               mem_wdata = val_ff;
               cnt_in    = cnt_ff + LW'(1);
            end
         end
         S_CLEAR: begin
            if (clear_issue) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_w[AW-1:0];
               mem_wdata = '0;
               ptr_in    = ptr_ff + LW'(1);
            end else begin
               cnt_in = newlen_w[LW-1:0];
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
               rsp_length_in = cnt_w[10:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         start_ff     <= '0;
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         ptr_ff       <= ptr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      chk_idx_ff    <= chk_idx_in;
      res_value_ff  <= res_value_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_length      = rsp_length_ff;

   // length never exceeds capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_w <= CAP_W)
      else $error("length above capacity");

   // a response is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response loaded outside done state");

   // during the shift, writes land above the entry being read
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && mem_we && mem_re) |-> (mem_waddr > mem_raddr))
      else $error("shift write overtakes read");

   // an accepted request leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_DECODE))
      else $error("request accepted without decode");

endmodule

`default_nettype wire

// ----- hw/rtl/iaif_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module iaif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire
